FILE: sv/smlp_pkg.sv
`default_nettype none

package smlp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;

  // Saturation limits (largest payload is clamped to 16 bits)
  localparam logic [15:0] SIZE_LIM     = 16'hFFFF;
  localparam logic [15:0] TYPE_LIM_POS = 16'd32767;
  localparam logic [15:0] TYPE_LIM_NEG = 16'd32768;

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_SIZE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DELIM    = 3'd1,
    ST_NAN      = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_OVF      = 3'd4
  } status_e;

  typedef struct packed {
    logic started;
    logic ended;
    logic digit;
    logic neg;
  } flags_t;

  typedef struct packed {
    logic [15:0] acc;
    flags_t      flags;
  } field_t;

  typedef struct packed {
    field_t fld;
    logic   ovf;
  } feed_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
  endfunction

  // Advance one decimal field by one character
  function automatic feed_t feed_field(field_t f, logic [7:0] c,
                                       logic [15:0] lim_pos, logic [15:0] lim_neg);
    feed_t       r;
    logic [19:0] v;
    logic [15:0] lim;
    r     = '{fld: f, ovf: 1'b0};
    lim   = f.flags.neg ? lim_neg : lim_pos;
    v     = 20'(f.acc) * 20'd10 + 20'(c - CHAR_ZERO);
    if (!f.flags.ended) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        if (v > 20'(lim)) begin
          r.fld.acc = lim;
          r.ovf     = 1'b1;
        end else begin
          r.fld.acc = v[15:0];
        end
        r.fld.flags.digit   = 1'b1;
        r.fld.flags.started = 1'b1;
      end else if (!f.flags.started) begin
        if (c == CHAR_MINUS) begin
          r.fld.flags.neg     = 1'b1;
          r.fld.flags.started = 1'b1;
        end else if (c == CHAR_PLUS) begin
          r.fld.flags.started = 1'b1;
        end else if (!is_space(c)) begin
          r.fld.flags.ended   = 1'b1;
          r.fld.flags.started = 1'b1;
        end
      end else begin
        r.fld.flags.ended = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/semicolon_line_message_parser.sv
`default_nettype none

// Parser for lines of the form type;size;data ended by LF, one byte per request.
// A byte is held in an input register and parsed from there into a result register,
// so the block takes one byte every cycle while the output is not stalled; while the
// result register is full and stalled, the byte waits and in_stall_o is high. CR bytes
// and the bytes of the type and size fields give no result; every byte after the
// second semicolon is passed out at once as a payload request, and LF gives one
// end record carrying type, size and status. Payload leaves before the line is
// checked, so the consumer must drop a message whose end status is not ok.
module semicolon_line_message_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_end_o,
  output logic [7:0]       payload_byte_o,
  output logic signed [15:0] msg_type_o,
  output logic [15:0]      msg_size_o,
  output logic [2:0]       status_o
);
  import smlp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        out_free;
  logic        advance;

  phase_e      phase_q, phase_d;
  field_t      type_q, type_d;
  field_t      size_q, size_d;
  logic [15:0] count_q, count_d;
  logic        ovf_q, ovf_d;

  logic        res_valid;
  logic        res_end;
  logic [7:0]  res_byte;
  logic [15:0] res_type;
  logic [15:0] res_size;
  status_e     res_status;

  logic        out_valid_q;
  logic        is_end_q;
  logic [7:0]  payload_q;
  logic [15:0] type_out_q;
  logic [15:0] size_out_q;
  status_e     status_q;

  feed_t       type_feed;
  feed_t       size_feed;

  // Hand the held byte on when the result register is free or being emptied
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  assign type_feed = feed_field(type_q, byte_q, TYPE_LIM_POS, TYPE_LIM_NEG);
  assign size_feed = feed_field(size_q, byte_q, SIZE_LIM, SIZE_LIM);

  // Parse the held byte
  always_comb begin
    phase_d    = phase_q;
    type_d     = type_q;
    size_d     = size_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    res_valid  = 1'b0;
    res_end    = 1'b0;
    res_byte   = '0;
    res_type   = '0;
    res_size   = '0;
    res_status = ST_OK;
    if (byte_q == CHAR_CR) begin
      // drop
    end else if (byte_q == CHAR_LF) begin
      res_valid = 1'b1;
      res_end   = 1'b1;
      if (phase_q == PH_TYPE || phase_q == PH_SIZE) begin
        res_status = ST_DELIM;
      end else begin
        res_type = type_q.flags.neg ? 16'(-type_q.acc) : type_q.acc;
        res_size = size_q.flags.neg ? 16'(-size_q.acc) : size_q.acc;
        priority if (!type_q.flags.digit || !size_q.flags.digit) begin
          res_status = ST_NAN;
        end else if (ovf_q) begin
          res_status = ST_OVF;
        end else if ((size_q.flags.neg && size_q.acc != '0) || size_q.acc != count_q) begin
          res_status = ST_MISMATCH;
        end else begin
          res_status = ST_OK;
        end
      end
      phase_d = PH_TYPE;
      type_d  = '0;
      size_d  = '0;
      count_d = '0;
      ovf_d   = 1'b0;
    end else begin
      unique case (phase_q)
        PH_TYPE: begin
          if (byte_q == CHAR_SEMI) begin
            phase_d = PH_SIZE;
          end else begin
            type_d = type_feed.fld;
            ovf_d  = ovf_q | type_feed.ovf;
          end
        end
        PH_SIZE: begin
          if (byte_q == CHAR_SEMI) begin
            phase_d = PH_PAYLOAD;
          end else begin
            size_d = size_feed.fld;
            ovf_d  = ovf_q | size_feed.ovf;
          end
        end
        default: begin
          // payload: pass the byte out and count it, saturating
          res_valid = 1'b1;
          res_byte  = byte_q;
          if (count_q >= SIZE_LIM) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + 16'd1;
          end
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      type_q  <= '0;
      size_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      size_q  <= size_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      is_end_q   <= res_end;
      payload_q  <= res_byte;
      type_out_q <= res_type;
      size_out_q <= res_size;
      status_q   <= res_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_end_o       = is_end_q;
  assign payload_byte_o = payload_q;
  assign msg_type_o     = $signed(type_out_q);
  assign msg_size_o     = size_out_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

FILE: bench/tb_semicolon_line_message_parser.sv
`timescale 1ns / 100ps

module tb_semicolon_line_message_parser;
  import smlp_pkg::*;

  // One result request as seen on the output side
  typedef struct packed {
    logic        is_end;
    logic [7:0]  pbyte;
    logic [15:0] mtype;
    logic [15:0] msize;
    logic [2:0]  st;
  } line_record_t;

  // Progress through one decimal field
  typedef struct packed {
    logic [15:0] mag;
    logic        neg;
    logic        digit;
    logic        done;
    logic        begun;
  } field_state_t;

  // Line parser prediction and the queue of records still to arrive
  class line_scoreboard;
    phase_e       ph;
    field_state_t type_fld;
    field_state_t size_fld;
    logic [15:0]  count;
    logic         ovf;
    line_record_t pending[$];
    int           failures;
    int           seen;

    function new();
      clear_line();
      failures = 0;
      seen     = 0;
    endfunction

    function void clear_line();
      ph       = PH_TYPE;
      type_fld = '0;
      size_fld = '0;
      count    = '0;
      ovf      = 1'b0;
    endfunction

    // Advance a field by one character; saturate and flag on overflow
    function field_state_t step_field(field_state_t f, logic [7:0] c,
                                      int unsigned lim_pos, int unsigned lim_neg);
      int unsigned acc;
      int unsigned lim;
      if (f.done) return f;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        lim = f.neg ? lim_neg : lim_pos;
        acc = 32'(f.mag) * 10 + 32'(c - CHAR_ZERO);
        if (acc > lim) begin
          acc = lim;
          ovf = 1'b1;
        end
        f.mag   = 16'(acc);
        f.digit = 1'b1;
        f.begun = 1'b1;
      end else if (!f.begun) begin
        if (c == CHAR_MINUS) begin
          f.neg   = 1'b1;
          f.begun = 1'b1;
        end else if (c == CHAR_PLUS) begin
          f.begun = 1'b1;
        end else if (!(c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF)) begin
          f.done  = 1'b1;
          f.begun = 1'b1;
        end
      end else begin
        f.done = 1'b1;
      end
      return f;
    endfunction

    // Note an accepted byte and queue whatever record it causes
    function void note_byte(logic [7:0] c);
      line_record_t r;
      r = '0;
      if (c == CHAR_CR) return;
      if (c == CHAR_LF) begin
        r.is_end = 1'b1;
        if (ph != PH_PAYLOAD) begin
          r.st = ST_DELIM;
        end else begin
          r.mtype = type_fld.neg ? 16'(0 - type_fld.mag) : type_fld.mag;
          r.msize = size_fld.neg ? 16'(0 - size_fld.mag) : size_fld.mag;
          if (!type_fld.digit || !size_fld.digit)
            r.st = ST_NAN;
          else if (ovf)
            r.st = ST_OVF;
          else if ((size_fld.neg && size_fld.mag != 0) || size_fld.mag != count)
            r.st = ST_MISMATCH;
          else
            r.st = ST_OK;
        end
        pending.push_back(r);
        clear_line();
      end else if (ph == PH_TYPE) begin
        if (c == CHAR_SEMI) ph = PH_SIZE;
        else type_fld = step_field(type_fld, c, TYPE_LIM_POS, TYPE_LIM_NEG);
      end else if (ph == PH_SIZE) begin
        if (c == CHAR_SEMI) ph = PH_PAYLOAD;
        else size_fld = step_field(size_fld, c, SIZE_LIM, SIZE_LIM);
      end else begin
        if (count >= SIZE_LIM) ovf = 1'b1;
        else count = count + 16'd1;
        r.pbyte = c;
        pending.push_back(r);
      end
    endfunction

    function void match(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
        failures++;
      end
    endfunction

    // Compare an accepted result with the oldest outstanding record
    function void check_record(logic is_end, logic [7:0] pbyte, logic [15:0] mtype,
                               logic [15:0] msize, logic [2:0] st);
      line_record_t want;
      seen++;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: is_end %0b byte 'h%0h status %0d",
               is_end, pbyte, st);
        failures++;
        return;
      end
      want = pending.pop_front();
      match("is_end", 16'(want.is_end), 16'(is_end));
      match("payload_byte", 16'(want.pbyte), 16'(pbyte));
      match("msg_type", want.mtype, mtype);
      match("msg_size", want.msize, msize);
      match("status", 16'(want.st), 16'(st));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  byte_in_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        is_end_o;
  logic [7:0]  payload_byte_o;
  logic signed [15:0] msg_type_o;
  logic [15:0] msg_size_o;
  logic [2:0]  status_o;

  line_scoreboard sb;
  logic [7:0]     line_q[$];
  bit             tx_steady = 1'b0;
  int             items_sent = 0;

  semicolon_line_message_parser DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_in_i      (byte_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_end_o       (is_end_o),
    .payload_byte_o (payload_byte_o),
    .msg_type_o     (msg_type_o),
    .msg_size_o     (msg_size_o),
    .status_o       (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly back to back, sometimes a short gap, rarely a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] blank();
    case ($urandom_range(0, 3))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_VT;
      default: return CHAR_FF;
    endcase
  endfunction

  // Any byte that neither ends the line nor is dropped
  function automatic logic [7:0] payload_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void put_number(int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(8'(CHAR_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    line_q = {line_q, digits};
  endfunction

  // Well-formed line with random content, now and then bent out of shape
  function automatic void build_frame();
    int plen;
    int sval;
    repeat ($urandom_range(0, 2)) line_q.push_back(blank());
    case ($urandom_range(0, 3))
      0:       line_q.push_back(CHAR_MINUS);
      1:       line_q.push_back(CHAR_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 9) != 0)
      put_number($urandom_range(0, 4) == 0 ? $urandom_range(0, 99999) : $urandom_range(0, 999));
    if ($urandom_range(0, 5) == 0)
      line_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(8'h61, 8'h7A)));
    line_q.push_back(CHAR_SEMI);
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    case ($urandom_range(0, 9))
      0:       sval = $urandom_range(0, 99999);
      1:       sval = plen + 1;
      default: sval = plen;
    endcase
    if ($urandom_range(0, 4) == 0) line_q.push_back(blank());
    if ($urandom_range(0, 9) == 0) line_q.push_back(CHAR_MINUS);
    else if ($urandom_range(0, 4) == 0) line_q.push_back(CHAR_PLUS);
    if ($urandom_range(0, 14) != 0) put_number(sval);
    if ($urandom_range(0, 7) == 0) line_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    line_q.push_back(CHAR_SEMI);
    repeat (plen) begin
      line_q.push_back(payload_char());
      if ($urandom_range(0, 19) == 0) line_q.push_back(CHAR_CR);
    end
  endfunction

  // Short run of bytes biased towards delimiters, digits and signs
  function automatic void build_noise();
    string pool = "0123456789;;;-+ ";
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 2) == 0) line_q.push_back(8'($urandom_range(0, 255)));
      else line_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    end
  endfunction

  // Offer one byte request and hold it until accepted
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
    items_sent++;
  endtask

  // Terminate the queued line with LF and send it
  task automatic send_line();
    tx_steady = ($urandom_range(0, 4) == 0);
    line_q.push_back(CHAR_LF);
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  // Check every accepted result request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_record(is_end_o, payload_byte_o, msg_type_o, msg_size_o, status_o);
  end

  // Stall the output at random; hold it off for long stretches to back up the input
  initial begin : result_sink
    int n;
    int holds;
    holds = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ((holds == 0 && sb.seen >= 60) || (holds == 1 && sb.seen >= 120)) begin
        n = 150;
        holds++;
      end else begin
        n = idle_len();
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk_i);
      else repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int target;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Good line: negative type, leading blank, extreme payload bytes, dropped CR
    put_text(" -5;2;");
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    line_q.push_back(CHAR_CR);
    send_line();
    // Line ends before the second semicolon
    put_text("1");
    send_line();
    // Neither field holds a digit
    put_text(";;");
    send_line();
    // Type saturates negative, size negative, semicolon carried as payload
    put_text("-40000;-1;;");
    send_line();
    // Junk after the type digits, blank before the size, no payload
    put_text("7z; 1;");
    send_line();

    // Random lines, mostly well formed
    target = items_sent + 420;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) build_noise();
      else build_frame();
      send_line();
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for anything stray
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.failures++;
    end
    if (sb.failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
